// ===== sv/bed_pkg.sv =====
// Shared constants, types and the structuring-element expansion for the
// binary erode/dilate block. No dependencies.
package bed_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_RADIUS = 3;
   localparam int WIN        = 2 * MAX_RADIUS + 1;
   localparam int WIN_IDX_W  = $clog2(WIN);
   localparam int LINE_W     = 2 * MAX_RADIUS;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = 10;
   localparam int DIM_W      = 11;
   localparam int RAD_W      = 2;
   localparam int MASK_W     = 49;
   localparam int MASK_IDX_W = $clog2(MASK_W);
   localparam int LAG_W      = DIM_W + RAD_W;
   localparam int LIN_W      = 2 * DIM_W;
   localparam int CSR_IDX_W  = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_MORPH_MODE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SE_RADIUS    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SE_MASK      = 3'd4;

   localparam logic MODE_ERODE  = 1'b0;
   localparam logic MODE_DILATE = 1'b1;

   typedef struct packed {
      logic                  mode;
      logic [DIM_W-1:0]      width;
      logic [DIM_W-1:0]      height;
      logic [RAD_W-1:0]      radius;
      logic [LAG_W-1:0]      lag;
      logic [MASK_W-1:0]     act;
   } cfg_type;

   typedef struct packed {
      logic                  keep;
      logic                  pix;
      logic [COL_W-1:0]      col;
      logic                  has_rsp;
      logic                  last;
      logic [WIN-1:0]        row_ok;
      logic [WIN-1:0]        col_ok;
   } item_type;

   // Remap the row-major element bits to window coordinates: bit k*WIN+j
   // covers the pixel k columns and j rows behind the newest one.
   function automatic logic [MASK_W-1:0] expand_mask(logic [MASK_W-1:0] mask,
                                                    logic [RAD_W-1:0] rad);
      logic [MASK_W-1:0]     act;
      logic [MASK_IDX_W-1:0] idx;
      int                    span;
      int                    side;
      act  = '0;
      span = 2 * int'(rad);
      side = span + 1;
      for (int k = 0; k < WIN; k++) begin
         for (int j = 0; j < WIN; j++) begin
            if (k <= span && j <= span) begin
               idx = MASK_IDX_W'((span - j) * side + (span - k));
               act[k*WIN+j] = mask[idx];
            end
         end
      end
      return act;
   endfunction

endpackage

// ===== sv/bed_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bed_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/bed_cfg.sv =====
// Configuration registers and derived geometry (clamped width, lag,
// expanded element mask). Depends on bed_pkg.
module bed_cfg (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [bed_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bed_pkg::MASK_W-1:0]       csr_wdata,
   output bed_pkg::cfg_type                 cfg
);
   import bed_pkg::*;

   logic                  mode_ff;
   logic [DIM_W-1:0]      width_ff;
   logic [DIM_W-1:0]      height_ff;
   logic [RAD_W-1:0]      radius_ff;
   logic [MASK_W-1:0]     mask_ff;
   logic [MASK_W-1:0]     act_ff;
   logic [DIM_W-1:0]      width_eff;
   logic [DIM_W-1:0]      height_eff;
   logic [LAG_W-1:0]      lag;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_ERODE;
         width_ff  <= DIM_W'(640);
         height_ff <= DIM_W'(480);
         radius_ff <= RAD_W'(1);
         mask_ff   <= MASK_W'(511);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MORPH_MODE:   mode_ff   <= csr_wdata[0];
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata[DIM_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata[DIM_W-1:0];
            CSR_SE_RADIUS:    radius_ff <= csr_wdata[RAD_W-1:0];
            CSR_SE_MASK:      mask_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      act_ff <= expand_mask(mask_ff, radius_ff);
   end

   always_comb begin
      if (width_ff == '0) begin
         width_eff = DIM_W'(1);
      end else if (width_ff > DIM_W'(MAX_WIDTH)) begin
         width_eff = DIM_W'(MAX_WIDTH);
      end else begin
         width_eff = width_ff;
      end
      height_eff = (height_ff == '0) ? DIM_W'(1) : height_ff;
      lag = (radius_ff[1] ? {width_eff, 1'b0, 1'b0} >> 1 : LAG_W'(0))
          + (radius_ff[0] ? LAG_W'(width_eff) : LAG_W'(0))
          + LAG_W'(radius_ff);
   end

   always_comb begin
      cfg.mode   = mode_ff;
      cfg.width  = width_eff;
      cfg.height = height_eff;
      cfg.radius = radius_ff;
      cfg.lag    = lag;
      cfg.act    = act_ff;
   end

endmodule

// ===== sv/bed_pos.sv =====
// Stream position tracking: input and output raster counters, result and
// frame-end decisions, border masks for each beat. Depends on bed_pkg.
module bed_pos (
   input  logic              clock,
   input  logic              reset,
   input  bed_pkg::cfg_type  cfg,
   input  logic              accept,
   input  logic              op,
   input  logic              pixel_in,
   output bed_pkg::item_type item
);
   import bed_pkg::*;

   logic [COL_W-1:0]  in_col_ff,   in_col_in;
   logic [LIN_W-1:0]  in_lin_ff,   in_lin_in;
   logic [ROW_W-1:0]  out_row_ff,  out_row_in;
   logic [COL_W-1:0]  out_col_ff,  out_col_in;
   logic [DIM_W-1:0]  in_col_inc;
   logic [DIM_W-1:0]  out_col_inc;
   logic [ROW_W+1:0]  row_sum;
   logic [COL_W+1:0]  col_sum;
   logic              keep;
   logic              has_rsp;
   logic              last;

   always_comb begin
      keep    = !(in_lin_ff == '0 && op);
      has_rsp = keep && (in_lin_ff >= LIN_W'(cfg.lag));
      last    = has_rsp && ({1'b0, out_row_ff} >= cfg.height - DIM_W'(1))
                        && ({1'b0, out_col_ff} >= cfg.width - DIM_W'(1));
      row_sum = (ROW_W+2)'(out_row_ff) + (ROW_W+2)'(cfg.radius);
      col_sum = (COL_W+2)'(out_col_ff) + (COL_W+2)'(cfg.radius);
      for (int j = 0; j < WIN; j++) begin
         item.row_ok[j] = (row_sum >= (ROW_W+2)'(j))
                       && ((DIM_W+1)'(row_sum - (ROW_W+2)'(j)) < {1'b0, cfg.height});
      end
      for (int k = 0; k < WIN; k++) begin
         item.col_ok[k] = (col_sum >= (COL_W+2)'(k))
                       && ((DIM_W+1)'(col_sum - (COL_W+2)'(k)) < {1'b0, cfg.width});
      end
      item.keep    = keep;
      item.pix     = op ? 1'b0 : pixel_in;
      item.col     = in_col_ff;
      item.has_rsp = has_rsp;
      item.last    = last;
   end

   always_comb begin
      in_col_inc  = DIM_W'(in_col_ff) + DIM_W'(1);
      out_col_inc = DIM_W'(out_col_ff) + DIM_W'(1);
      in_col_in   = in_col_ff;
      in_lin_in   = in_lin_ff;
      out_row_in  = out_row_ff;
      out_col_in  = out_col_ff;
      if (accept && keep) begin
         in_col_in = (in_col_inc >= cfg.width) ? '0 : in_col_inc[COL_W-1:0];
         in_lin_in = in_lin_ff + LIN_W'(1);
         if (has_rsp) begin
            if (out_col_inc >= cfg.width) begin
               out_col_in = '0;
               out_row_in = out_row_ff + ROW_W'(1);
            end else begin
               out_col_in = out_col_inc[COL_W-1:0];
            end
         end
         if (last) begin
            in_col_in  = '0;
            in_lin_in  = '0;
            out_row_in = '0;
            out_col_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_lin_ff  <= '0;
         out_row_ff <= '0;
         out_col_ff <= '0;
      end else begin
         in_col_ff  <= in_col_in;
         in_lin_ff  <= in_lin_in;
         out_row_ff <= out_row_in;
         out_col_ff <= out_col_in;
      end
   end

endmodule

// ===== sv/bed_window.sv =====
// Line-buffer read-modify-write, 7x7 window register, morphology decision
// and result register with beat flow control. Depends on bed_pkg, bed_ram.
module bed_window (
   input  logic              clock,
   input  logic              reset,
   input  bed_pkg::cfg_type  cfg,
   input  bed_pkg::item_type item,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              accept,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_pixel_out,
   output logic              rsp_frame_last
);
   import bed_pkg::*;

   item_type          b_item_ff;
   logic              b_valid_ff, b_valid_in;
   logic              fwd_ff;
   logic [LINE_W-1:0] fwd_data_ff;
   logic              o_valid_ff, o_valid_in;
   logic              o_pixel_ff;
   logic              o_last_ff;
   logic [WIN-1:0]    win_ff   [WIN];
   logic [WIN-1:0]    win_next [WIN];
   logic [LINE_W-1:0] rd_data;
   logic [LINE_W-1:0] line_word;
   logic [LINE_W-1:0] wr_data;
   logic              o_free;
   logic              b_adv;
   logic              b_load;
   logic              hit;
   logic              centre;
   logic              result;

   always_comb begin
      o_free     = !o_valid_ff || !rsp_stall;
      b_adv      = b_valid_ff && (!b_item_ff.has_rsp || o_free);
      req_stall  = b_valid_ff && !b_adv;
      accept     = req_valid && !req_stall;
      b_load     = accept && item.keep;
      b_valid_in = req_stall ? b_valid_ff : b_load;
      o_valid_in = o_free ? (b_adv && b_item_ff.has_rsp) : o_valid_ff;
   end

   bed_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (b_adv),
      .wr_addr (b_item_ff.col),
      .wr_data (wr_data),
      .rd_en   (b_load),
      .rd_addr (item.col),
      .rd_data (rd_data)
   );

   always_comb begin
      line_word = fwd_ff ? fwd_data_ff : rd_data;
      wr_data   = {line_word[LINE_W-2:0], b_item_ff.pix};
      win_next[0] = {line_word, b_item_ff.pix};
      for (int k = 1; k < WIN; k++) begin
         win_next[k] = win_ff[k-1];
      end
   end

   always_comb begin
      hit = 1'b0;
      for (int k = 0; k < WIN; k++) begin
         for (int j = 0; j < WIN; j++) begin
            hit = hit | (cfg.act[k*WIN+j] & b_item_ff.row_ok[j] & b_item_ff.col_ok[k]
                         & ((cfg.mode == MODE_DILATE) ? win_next[k][j] : ~win_next[k][j]));
         end
      end
      centre = win_next[WIN_IDX_W'(cfg.radius)][WIN_IDX_W'(cfg.radius)];
      result = (cfg.mode == MODE_DILATE) ? (centre | hit) : (centre & ~hit);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= b_valid_in;
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (b_load) begin
         b_item_ff   <= item;
         fwd_ff      <= b_adv && (b_item_ff.col == item.col);
         fwd_data_ff <= wr_data;
      end
      if (b_adv) begin
         for (int k = 0; k < WIN; k++) begin
            win_ff[k] <= win_next[k];
         end
      end
      if (o_free && b_adv && b_item_ff.has_rsp) begin
         o_pixel_ff <= result;
         o_last_ff  <= b_item_ff.last;
      end
   end

   assign rsp_valid      = o_valid_ff;
   assign rsp_pixel_out  = o_pixel_ff;
   assign rsp_frame_last = o_last_ff;

endmodule

// ===== sv/binary_erode_dilate.sv =====
// Binary erosion / dilation over a raster pixel stream, up to 7x7 element.
// Takes one beat per cycle unless the output stalls; a result is registered
// after the beat that completes its window, R*width+R beats after its own pixel.
// Line buffer read-modify-write is forwarded, so equal columns back to back
// keep full rate. Reset restores register defaults and clears the position
// counters; line buffer contents are not cleared (border masking hides them).
module binary_erode_dilate (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_op,
   input  logic                          req_pixel_in,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_pixel_out,
   output logic                          rsp_frame_last,
   input  logic                          csr_wr_en,
   input  logic [bed_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bed_pkg::MASK_W-1:0]    csr_wdata
);
   import bed_pkg::*;

   cfg_type  cfg;
   item_type item;
   logic     accept;

   bed_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bed_pos u_pos (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .accept   (accept),
      .op       (req_op),
      .pixel_in (req_pixel_in),
      .item     (item)
   );

   bed_window u_window (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .item           (item),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .accept         (accept),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule
